// ===== src/assert_macros.svh =====
// Assertion macros shared by the encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define B64_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("b64le assertion failed");

// Same check with a message of the caller's choice.
`define B64_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`endif

// ===== src/b64le_pkg.sv =====
// Types, constants and the alphabet lookup for the Base64 line encoder.
`timescale 1ns / 1ps

package b64le_pkg;

  localparam int GroupsPerLineDef = 16;
  localparam int QueueDepthDef    = 4;

  // Configuration register indexes
  localparam logic [1:0] CfgNoLineBreaks = 2'd0;
  localparam logic [1:0] CfgNoPadding    = 2'd1;

  localparam logic [7:0] CharPad = 8'h3D;
  localparam logic [7:0] CharCr  = 8'h0D;
  localparam logic [7:0] CharLf  = 8'h0A;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } out_t;

  // One unit of output work: sextet bits, then padding, then CR LF pairs.
  typedef struct packed {
    logic [23:0] bits;
    logic [2:0]  num_sextets;
    logic [1:0]  num_pad;
    logic [1:0]  num_crlf;
    logic        last;
  } job_t;

  typedef struct packed {
    logic [1:0] byte_pos;
  } front_sts_t;

  function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

// ===== src/b64le_front.sv =====
// Front end: takes bytes, builds groups, counts line groups, queues output jobs.
`timescale 1ns / 1ps

module b64le_front #(
  parameter int GROUPS_PER_LINE = b64le_pkg::GroupsPerLineDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  b64le_pkg::in_t        in_data_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic                  cfg_data_i,
  output logic                  job_valid_o,
  input  logic                  job_ready_i,
  output b64le_pkg::job_t       job_o,
  output b64le_pkg::front_sts_t sts_o
);

  localparam int GW = (GROUPS_PER_LINE > 1) ? $clog2(GROUPS_PER_LINE) : 1;
  localparam logic [GW-1:0] GrpLast = GW'(GROUPS_PER_LINE - 1);

  logic          no_lb_q, no_pad_q;
  logic [15:0]   held_q, held_d;
  logic [1:0]    pos_q, pos_d;
  logic [GW-1:0] grp_q, grp_d;

  logic accept, complete, wrap, brk_periodic, brk_final;
  logic [15:0] held_n;
  logic [1:0]  pos_n;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = job_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign sts_o.byte_pos = pos_q;

  always_comb begin
    complete     = (pos_q == 2'd2);
    wrap         = complete && (grp_q == GrpLast);
    brk_periodic = wrap && !no_lb_q;
    brk_final    = in_data_i.last_byte && !no_lb_q;
    held_n       = complete ? 16'h0000 : {held_q[7:0], in_data_i.data_byte};
    pos_n        = complete ? 2'd0 : pos_q + 2'd1;

    job_o.bits        = {held_q, in_data_i.data_byte};
    job_o.num_sextets = 3'd4;
    job_o.num_pad     = 2'd0;
    job_o.num_crlf    = {1'b0, brk_periodic} + {1'b0, brk_final};
    job_o.last        = in_data_i.last_byte;
    if (!complete) begin
      if (pos_n == 2'd1) begin
        job_o.bits        = {held_n[7:0], 16'h0000};
        job_o.num_sextets = 3'd2;
        job_o.num_pad     = no_pad_q ? 2'd0 : 2'd2;
      end else begin
        job_o.bits        = {held_n, 8'h00};
        job_o.num_sextets = 3'd3;
        job_o.num_pad     = no_pad_q ? 2'd0 : 2'd1;
      end
    end
    job_valid_o = in_valid_i && (complete || in_data_i.last_byte);

    held_d = held_q;
    pos_d  = pos_q;
    grp_d  = grp_q;
    if (accept) begin
      held_d = held_n;
      pos_d  = pos_n;
      if (complete) begin
        grp_d = wrap ? '0 : grp_q + GW'(1);
      end
      // end of message: start the next one clean
      if (in_data_i.last_byte) begin
        held_d = 16'h0000;
        pos_d  = 2'd0;
        grp_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q   <= 16'h0000;
      pos_q    <= 2'd0;
      grp_q    <= '0;
      no_lb_q  <= 1'b0;
      no_pad_q <= 1'b0;
    end else begin
      held_q <= held_d;
      pos_q  <= pos_d;
      grp_q  <= grp_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == b64le_pkg::CfgNoLineBreaks) begin
          no_lb_q <= cfg_data_i;
        end
        if (cfg_index_i == b64le_pkg::CfgNoPadding) begin
          no_pad_q <= cfg_data_i;
        end
      end
    end
  end

endmodule

// ===== src/b64le_queue.sv =====
// Short job queue between the front and back ends.
`timescale 1ns / 1ps

module b64le_queue #(
  parameter int DEPTH = b64le_pkg::QueueDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  b64le_pkg::job_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output b64le_pkg::job_t pop_data_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PtrLast = AW'(DEPTH - 1);

  b64le_pkg::job_t mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic push, pop;

  assign push_ready_o = (cnt_q != CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + AW'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + AW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

// ===== src/b64le_back.sv =====
// Back end: walks each job one character per cycle into the output register while the output can move.
`timescale 1ns / 1ps

module b64le_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  output logic            job_ready_o,
  input  b64le_pkg::job_t job_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output b64le_pkg::out_t out_data_o
);

  logic [2:0]      step_q, step_d;
  logic            ovld_q, ovld_d;
  b64le_pkg::out_t odat_q, odat_d;

  logic       adv, emit, final_step;
  logic [3:0] total, step_w, rest;
  logic [5:0] sextet;
  logic [7:0] ch;

  always_comb begin
    total  = {1'b0, job_i.num_sextets} + {2'b00, job_i.num_pad}
           + {1'b0, job_i.num_crlf, 1'b0};
    step_w = {1'b0, step_q};
    rest   = step_w - {1'b0, job_i.num_sextets} - {2'b00, job_i.num_pad};

    unique case (step_q[1:0])
      2'd0:    sextet = job_i.bits[23:18];
      2'd1:    sextet = job_i.bits[17:12];
      2'd2:    sextet = job_i.bits[11:6];
      default: sextet = job_i.bits[5:0];
    endcase

    if (step_w < {1'b0, job_i.num_sextets}) begin
      ch = b64le_pkg::sextet_to_char(sextet);
    end else if (step_w < {1'b0, job_i.num_sextets} + {2'b00, job_i.num_pad}) begin
      ch = b64le_pkg::CharPad;
    end else begin
      ch = rest[0] ? b64le_pkg::CharLf : b64le_pkg::CharCr;
    end

    final_step  = (step_w == total - 4'd1);
    adv         = !ovld_q || out_ready_i;
    emit        = job_valid_i && adv;
    job_ready_o = emit && final_step;

    step_d = step_q;
    if (emit) begin
      step_d = final_step ? 3'd0 : step_q + 3'd1;
    end

    ovld_d = ovld_q;
    odat_d = odat_q;
    if (adv) begin
      ovld_d           = job_valid_i;
      odat_d.out_char  = ch;
      odat_d.last_char = job_i.last && final_step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 3'd0;
      ovld_q <= 1'b0;
    end else begin
      step_q <= step_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    odat_q <= odat_d;
  end

  assign out_valid_o = ovld_q;
  assign out_data_o  = odat_q;

endmodule

// ===== src/base64_line_encoder_top.sv =====
// Top level of the streaming Base64 encoder with CR LF line breaking.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) takes one message byte
//   per request; last_byte marks the final byte of a message.
//   Output channel (out_valid_o / out_ready_i / out_data_o) gives one ASCII
//   character per request; last_char marks the final character of a message.
//   Config channel (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i) is
//   always ready; index 0 turns off line breaks, index 1 turns off padding.
//   Write it only while the block is idle.
// Timing:
//   The first character of a completed group passes through the job queue and
//   then the output register. The back end emits one character per cycle
//   while the output can move, so three bytes give four characters (more with
//   breaks). Bytes are taken every cycle while the job queue has room.
// Reset clears the group state, the line counter and both config bits.
// A stalled receiver holds the output register; the queue then fills and
// in_ready_o drops until characters drain.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module base64_line_encoder_top #(
  parameter int GROUPS_PER_LINE = b64le_pkg::GroupsPerLineDef,
  parameter int QUEUE_DEPTH     = b64le_pkg::QueueDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  b64le_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output b64le_pkg::out_t out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [1:0]      cfg_index_i,
  input  logic            cfg_data_i
);

  logic                  push_valid, push_ready, pop_valid, pop_ready;
  logic                  in_accept;
  b64le_pkg::job_t       push_job, pop_job;
  b64le_pkg::front_sts_t front_sts;

  assign in_accept = in_valid_i && in_ready_o;

  b64le_front #(
    .GROUPS_PER_LINE(GROUPS_PER_LINE)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .job_valid_o(push_valid),
    .job_ready_i(push_ready),
    .job_o      (push_job),
    .sts_o      (front_sts)
  );

  b64le_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_job),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_job)
  );

  b64le_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(pop_valid),
    .job_ready_o(pop_ready),
    .job_i      (pop_job),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  `B64_ASSERT(a_last_clears_group, in_accept && in_data_i.last_byte |=> front_sts.byte_pos == 2'd0)
  `B64_ASSERT_MSG(a_no_lost_job, push_valid && !push_ready |-> !in_ready_o, "byte taken, job refused")
  `B64_ASSERT_MSG(a_pop_has_job, pop_ready |-> pop_valid, "pop from an empty queue")

endmodule
